@@ rtl/gow_pkg.sv @@
// Shared types and constants for the glyph outline walker.
`default_nettype none

package gow_pkg;

  // Value that marks an empty bounding box corner.
  localparam logic signed [15:0] EMPTY_MARK = 16'sd30000;
  localparam logic signed [15:0] EMPTY_MARK_NEG = -16'sd30000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BEGIN_LOOP     = 2'd0,
    CFG_END_BEGIN_LOOP = 2'd1,
    CFG_RET_END_LOOP   = 2'd2,
    CFG_RETURN         = 2'd3
  } cfg_index_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_FINISH = 2'd1,
    KIND_BAD    = 2'd2
  } kind_e;

  // Which word of the program is expected next.
  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_COUNT  = 2'd1,
    PH_X      = 2'd2,
    PH_Y      = 2'd3
  } phase_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_RUN    = 2'd0,
    ST_READ   = 2'd1,
    ST_POP    = 2'd2,
    ST_FINISH = 2'd3
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // process the accepted program word
    logic pop_read;  // read the stack entry below the count
    logic pop_emit;  // emit the entry read and drop it from the stack
    logic finish;    // emit the finish result and clear the glyph
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic word_emits;  // the presented word would emit a result at once
    logic ret_word;    // the presented word is a return opcode
    logic count_gt1;   // more than one start is saved
    logic out_free;    // the output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/gow_datapath.sv @@
// Datapath of the glyph outline walker: registers, start stack, box and output register.
`default_nettype none

module gow_datapath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire logic signed [15:0]  program_word_i,
  input  wire gow_pkg::dp_cmd_t    cmd_i,
  output gow_pkg::dp_status_t      status_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               kind_o,
  output logic signed [15:0]       vertex_x_o,
  output logic signed [15:0]       vertex_y_o,
  output logic signed [15:0]       box_left_o,
  output logic signed [15:0]       box_bottom_o,
  output logic signed [15:0]       box_right_o,
  output logic signed [15:0]       box_top_o,
  output logic                     overflowed_o,
  output logic                     last_of_run_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  // Opcode registers.
  logic signed [15:0] op_begin_q, op_end_begin_q, op_ret_end_q, op_return_q;

  // Parser and glyph state.
  gow_pkg::phase_e    phase_q, phase_d;
  logic [14:0]        left_q, left_d;
  logic signed [15:0] pend_x_q, pend_x_d;
  logic               loop_vtx_q, loop_vtx_d;
  logic               glyph_vtx_q, glyph_vtx_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [15:0] box_l_q, box_b_q, box_r_q, box_t_q;
  logic signed [15:0] box_l_d, box_b_d, box_r_d, box_t_d;
  logic               ovf_q, ovf_d;
  logic signed [15:0] top_x_q, top_y_q;

  // Start stack and its registered read port.
  logic [31:0]        stack_mem [STACK_DEPTH];
  logic [31:0]        rd_q;
  logic               push;
  logic [CW-1:0]      below_count;

  // Output register.
  logic               out_valid_q, out_valid_d;
  gow_pkg::kind_e     kind_q, kind_d;
  logic signed [15:0] vx_q, vy_q, bl_q, bb_q, br_q, bt_q;
  logic signed [15:0] vx_d, vy_d, bl_d, bb_d, br_d, bt_d;
  logic               ovo_q, ovo_d, last_q, last_d;

  // Word decode.
  logic is_loop, is_ret, is_bad, count_full, emit, emit_vtx, clear, out_free;
  logic [14:0] left_dec;

  assign is_loop = (program_word_i == op_end_begin_q) || (program_word_i == op_begin_q);
  assign is_ret = !is_loop &&
                  ((program_word_i == op_ret_end_q) || (program_word_i == op_return_q));
  assign is_bad = !is_loop && !is_ret;
  assign count_full = (count_q == CW'(STACK_DEPTH));
  assign out_free = !out_valid_q || out_ready_i;
  assign below_count = count_q - CW'(1);
  assign left_dec = (left_q != 15'd0) ? left_q - 15'd1 : 15'd0;
  assign push = cmd_i.take && (phase_q == gow_pkg::PH_Y) && !loop_vtx_q && !count_full;

  // Status toward the controller.
  always_comb begin
    status_o.out_free = out_free;
    status_o.count_gt1 = count_q > CW'(1);
    status_o.ret_word = (phase_q == gow_pkg::PH_OPCODE) && is_ret;
    case (phase_q)
      gow_pkg::PH_OPCODE: status_o.word_emits = is_bad || (is_loop && glyph_vtx_q);
      gow_pkg::PH_Y:      status_o.word_emits = 1'b1;
      default:            status_o.word_emits = 1'b0;
    endcase
  end

  // Result selection and next state of the walker.
  always_comb begin
    emit = 1'b0;
    emit_vtx = 1'b0;
    clear = 1'b0;
    kind_d = gow_pkg::KIND_VERTEX;
    vx_d = '0;
    vy_d = '0;
    bl_d = '0;
    bb_d = '0;
    br_d = '0;
    bt_d = '0;
    ovo_d = ovf_q;
    last_d = 1'b1;
    phase_d = phase_q;
    left_d = left_q;
    pend_x_d = pend_x_q;
    loop_vtx_d = loop_vtx_q;
    glyph_vtx_d = glyph_vtx_q;
    count_d = count_q;
    ovf_d = ovf_q;

    if (cmd_i.take) begin
      case (phase_q)
        gow_pkg::PH_OPCODE: begin
          if (is_loop) begin
            // A new loop closes the previous one with its saved start.
            if (glyph_vtx_q) begin
              emit_vtx = 1'b1;
              vx_d = top_x_q;
              vy_d = top_y_q;
            end
            loop_vtx_d = 1'b0;
            phase_d = gow_pkg::PH_COUNT;
          end else if (is_bad) begin
            emit = 1'b1;
            kind_d = gow_pkg::KIND_BAD;
            clear = 1'b1;
          end
        end
        gow_pkg::PH_COUNT: begin
          if (program_word_i < 16'sd1) begin
            left_d = '0;
            phase_d = gow_pkg::PH_OPCODE;
          end else begin
            left_d = program_word_i[14:0];
            phase_d = gow_pkg::PH_X;
          end
        end
        gow_pkg::PH_X: begin
          pend_x_d = program_word_i;
          phase_d = gow_pkg::PH_Y;
        end
        default: begin
          emit_vtx = 1'b1;
          vx_d = pend_x_q;
          vy_d = program_word_i;
          // The first vertex of a loop is saved, or flagged when the stack is full.
          if (!loop_vtx_q) begin
            if (count_full) begin
              ovf_d = 1'b1;
              ovo_d = 1'b1;
            end else begin
              count_d = count_q + CW'(1);
            end
          end
          loop_vtx_d = 1'b1;
          glyph_vtx_d = 1'b1;
          left_d = left_dec;
          phase_d = (left_dec != 15'd0) ? gow_pkg::PH_X : gow_pkg::PH_OPCODE;
        end
      endcase
    end else if (cmd_i.pop_emit) begin
      emit_vtx = 1'b1;
      vx_d = rd_q[31:16];
      vy_d = rd_q[15:0];
      last_d = 1'b0;
      count_d = below_count;
    end else if (cmd_i.finish) begin
      emit = 1'b1;
      kind_d = gow_pkg::KIND_FINISH;
      clear = 1'b1;
      // A box that never moved off the marker reports the marker on all sides.
      if (box_l_q == gow_pkg::EMPTY_MARK) begin
        bl_d = gow_pkg::EMPTY_MARK;
        bb_d = gow_pkg::EMPTY_MARK;
        br_d = gow_pkg::EMPTY_MARK;
        bt_d = gow_pkg::EMPTY_MARK;
      end else begin
        bl_d = box_l_q;
        bb_d = box_b_q;
        br_d = box_r_q;
        bt_d = box_t_q;
      end
    end

    // Every emitted vertex widens the box.
    box_l_d = box_l_q;
    box_b_d = box_b_q;
    box_r_d = box_r_q;
    box_t_d = box_t_q;
    if (emit_vtx) begin
      emit = 1'b1;
      if (vx_d < box_l_q) box_l_d = vx_d;
      if (vy_d < box_b_q) box_b_d = vy_d;
      if (vx_d > box_r_q) box_r_d = vx_d;
      if (vy_d > box_t_q) box_t_d = vy_d;
    end

    // The end of a glyph returns the walker to its reset state.
    if (clear) begin
      phase_d = gow_pkg::PH_OPCODE;
      left_d = '0;
      pend_x_d = '0;
      loop_vtx_d = 1'b0;
      glyph_vtx_d = 1'b0;
      count_d = '0;
      box_l_d = gow_pkg::EMPTY_MARK;
      box_b_d = gow_pkg::EMPTY_MARK;
      box_r_d = gow_pkg::EMPTY_MARK_NEG;
      box_t_d = gow_pkg::EMPTY_MARK_NEG;
      ovf_d = 1'b0;
    end

    out_valid_d = emit || (out_valid_q && !out_ready_i);
  end

  // Opcode registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_begin_q <= 16'sd1;
      op_end_begin_q <= 16'sd2;
      op_ret_end_q <= 16'sd3;
      op_return_q <= 16'sd4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gow_pkg::CFG_BEGIN_LOOP:     op_begin_q <= cfg_data_i;
        gow_pkg::CFG_END_BEGIN_LOOP: op_end_begin_q <= cfg_data_i;
        gow_pkg::CFG_RET_END_LOOP:   op_ret_end_q <= cfg_data_i;
        gow_pkg::CFG_RETURN:         op_return_q <= cfg_data_i;
        default:                     op_return_q <= op_return_q;
      endcase
    end
  end

  // Walker state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gow_pkg::PH_OPCODE;
      left_q <= '0;
      pend_x_q <= '0;
      loop_vtx_q <= 1'b0;
      glyph_vtx_q <= 1'b0;
      count_q <= '0;
      box_l_q <= gow_pkg::EMPTY_MARK;
      box_b_q <= gow_pkg::EMPTY_MARK;
      box_r_q <= gow_pkg::EMPTY_MARK_NEG;
      box_t_q <= gow_pkg::EMPTY_MARK_NEG;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q <= left_d;
      pend_x_q <= pend_x_d;
      loop_vtx_q <= loop_vtx_d;
      glyph_vtx_q <= glyph_vtx_d;
      count_q <= count_d;
      box_l_q <= box_l_d;
      box_b_q <= box_b_d;
      box_r_q <= box_r_d;
      box_t_q <= box_t_d;
      ovf_q <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Newest saved start, kept beside the stack for the loop re-emit.
  always_ff @(posedge clk_i) begin
    if (push) begin
      top_x_q <= pend_x_q;
      top_y_q <= program_word_i;
    end
  end

  // Start stack memory with a registered read.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[count_q[AW-1:0]] <= {pend_x_q, program_word_i};
    end
    if (cmd_i.pop_read) begin
      rd_q <= stack_mem[below_count[AW-1:0]];
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= kind_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
      bl_q <= bl_d;
      bb_q <= bb_d;
      br_q <= br_d;
      bt_q <= bt_d;
      ovo_q <= ovo_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o = kind_q;
  assign vertex_x_o = vx_q;
  assign vertex_y_o = vy_q;
  assign box_left_o = bl_q;
  assign box_bottom_o = bb_q;
  assign box_right_o = br_q;
  assign box_top_o = bt_q;
  assign overflowed_o = ovo_q;
  assign last_of_run_o = last_q;

endmodule

`default_nettype wire

@@ rtl/gow_ctrl.sv @@
// Controller of the glyph outline walker: input handshake and stack unwind sequence.
`default_nettype none

module gow_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire gow_pkg::dp_status_t status_i,
  output gow_pkg::dp_cmd_t         cmd_o
);

  gow_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gow_pkg::ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gow_pkg::ST_RUN: begin
        // Words that emit nothing pass even while a result waits.
        in_ready_o = status_i.out_free || !status_i.word_emits;
        if (in_valid_i && in_ready_o) begin
          cmd_o.take = 1'b1;
          if (status_i.ret_word) state_d = gow_pkg::ST_READ;
        end
      end
      gow_pkg::ST_READ: begin
        if (status_i.count_gt1) begin
          cmd_o.pop_read = 1'b1;
          state_d = gow_pkg::ST_POP;
        end else begin
          state_d = gow_pkg::ST_FINISH;
        end
      end
      gow_pkg::ST_POP: begin
        if (status_i.out_free) begin
          cmd_o.pop_emit = 1'b1;
          state_d = gow_pkg::ST_READ;
        end
      end
      gow_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = gow_pkg::ST_RUN;
        end
      end
      default: state_d = gow_pkg::ST_RUN;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/glyph_outline_walker.sv @@
// Top level of the glyph outline walker.
`default_nettype none

// The walker takes one program word per cycle whenever that word emits no result
// or the output register is free, so count and x words and return opcodes never
// stall; a y word, a bad opcode or a loop re-emit needs only a free output slot.
// A taken return opcode then unwinds the start stack, popping every saved start
// but the oldest, each by a registered stack memory read and then an emit, and
// then emits the finish result once it sees that no start is left to pop; the
// pop emits and the finish wait while the output is stalled, and no word is
// taken meanwhile. Opcode values must be written through the configuration port
// only while the block is idle; the block itself does not enforce this.
module glyph_outline_walker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] program_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              kind_o,
  output logic signed [15:0]      vertex_x_o,
  output logic signed [15:0]      vertex_y_o,
  output logic signed [15:0]      box_left_o,
  output logic signed [15:0]      box_bottom_o,
  output logic signed [15:0]      box_right_o,
  output logic signed [15:0]      box_top_o,
  output logic                    overflowed_o,
  output logic                    last_of_run_o
);

  gow_pkg::dp_cmd_t    cmd;
  gow_pkg::dp_status_t status;

  gow_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gow_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .program_word_i (program_word_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .kind_o         (kind_o),
    .vertex_x_o     (vertex_x_o),
    .vertex_y_o     (vertex_y_o),
    .box_left_o     (box_left_o),
    .box_bottom_o   (box_bottom_o),
    .box_right_o    (box_right_o),
    .box_top_o      (box_top_o),
    .overflowed_o   (overflowed_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

@@ rtl/gow_checker.sv @@
// Port-level assertions for the glyph outline walker and their bind.
`default_nettype none

module gow_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [1:0]         kind_o,
  input wire logic signed [15:0] vertex_x_o,
  input wire logic signed [15:0] vertex_y_o,
  input wire logic signed [15:0] box_left_o,
  input wire logic signed [15:0] box_bottom_o,
  input wire logic signed [15:0] box_right_o,
  input wire logic signed [15:0] box_top_o,
  input wire logic               last_of_run_o
);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // Finish and error results always close the run of their word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != gow_pkg::KIND_VERTEX) |-> last_of_run_o)
    else $error("glyph end result not marked last");

  // Only vertex results carry coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != gow_pkg::KIND_VERTEX) |-> (vertex_x_o == 16'sd0) &&
    (vertex_y_o == 16'sd0))
    else $error("coordinates on a non-vertex result");

  // Only finish results carry a box.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != gow_pkg::KIND_FINISH) |-> (box_left_o == 16'sd0) &&
    (box_bottom_o == 16'sd0) && (box_right_o == 16'sd0) && (box_top_o == 16'sd0))
    else $error("box on a non-finish result");

  // An empty box reports the marker on all four sides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == gow_pkg::KIND_FINISH) &&
    (box_left_o == gow_pkg::EMPTY_MARK) |-> (box_bottom_o == gow_pkg::EMPTY_MARK) &&
    (box_right_o == gow_pkg::EMPTY_MARK) && (box_top_o == gow_pkg::EMPTY_MARK))
    else $error("empty box not fully marked");

endmodule

bind glyph_outline_walker gow_checker u_gow_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .kind_o        (kind_o),
  .vertex_x_o    (vertex_x_o),
  .vertex_y_o    (vertex_y_o),
  .box_left_o    (box_left_o),
  .box_bottom_o  (box_bottom_o),
  .box_right_o   (box_right_o),
  .box_top_o     (box_top_o),
  .last_of_run_o (last_of_run_o)
);

`default_nettype wire
